>>> src/rmc_pkg.sv
// Package for the running mean and covariance unit: shared widths, codes and
// the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package rmc_pkg;

   localparam int DimDefault = 4;
   localparam int StoreDim   = 4;
   localparam int SampleW    = 32;
   localparam int CovW       = 64;
   localparam int CountW     = 32;

   // Index counter operations.
   localparam logic [1:0] IdxHold  = 2'd0;
   localparam logic [1:0] IdxFirst = 2'd1;
   localparam logic [1:0] IdxNext  = 2'd2;
   localparam logic [1:0] IdxNextA = 2'd3;

   // Divider operand selection.
   localparam logic [1:0] DivProd = 2'd0;
   localparam logic [1:0] DivTerm = 2'd1;
   localparam logic [1:0] DivCov  = 2'd2;
   localparam logic [1:0] DivMean = 2'd3;

   // Input command codes.
   localparam logic CmdAdd   = 1'b0;
   localparam logic CmdClear = 1'b1;

   typedef struct packed {
      logic       load;
      logic       clear;
      logic [1:0] idx_op;
      logic       res_sel_b;
      logic       lat_a;
      logic       lat_p;
      logic       div_start;
      logic [1:0] div_op;
      logic       cov_wr;
      logic       emit_cov;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic a_last;
      logic b_last;
   } status_type;

endpackage

`default_nettype wire

>>> src/rmc_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on nothing.
`default_nettype none

interface rmc_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic signed [31:0] sample_0;
   logic signed [31:0] sample_1;
   logic signed [31:0] sample_2;
   logic signed [31:0] sample_3;
   modport source (output valid, cmd, sample_0, sample_1, sample_2, sample_3, input ready);
   modport sink   (input valid, cmd, sample_0, sample_1, sample_2, sample_3, output ready);
   modport monitor (input valid, ready, cmd, sample_0, sample_1, sample_2, sample_3);
endinterface

interface rmc_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [1:0]         row_index;
   logic [1:0]         col_index;
   logic signed [63:0] value;
   logic               last;
   modport source (output valid, kind, row_index, col_index, value, last, input ready);
   modport sink   (input valid, kind, row_index, col_index, value, last, output ready);
   modport monitor (input valid, ready, kind, row_index, col_index, value, last);
endinterface

`default_nettype wire

>>> src/rmc_div.sv
// Bit-serial restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// Depends on rmc_pkg.
`default_nettype none

module rmc_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [rmc_pkg::CovW-1:0]    dividend,
   input  wire logic [rmc_pkg::CountW-1:0]  divisor,
   output logic                             done,
   output logic [rmc_pkg::CovW-1:0]         quotient
);

   logic [rmc_pkg::CovW-1:0]   quo_ff, quo_in;
   logic [rmc_pkg::CountW-1:0] rem_ff, rem_in;
   logic [rmc_pkg::CountW-1:0] dvs_ff, dvs_in;
   logic [5:0]                 cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [rmc_pkg::CountW:0]   shifted;
   logic                       fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[rmc_pkg::CovW-1]};
      fits    = shifted >= {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = 6'd63;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[rmc_pkg::CovW-2:0], fits};
         rem_in = fits ? rmc_pkg::CountW'(shifted - {1'b0, dvs_ff})
                       : shifted[rmc_pkg::CountW-1:0];
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> src/rmc_datapath.sv
// Datapath: statistics registers, residuals, multiplier, shared divider and result words.
// Depends on rmc_pkg and rmc_div.
`default_nettype none

module rmc_datapath #(
   parameter int DIM = rmc_pkg::DimDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rmc_pkg::cmd_type     cmd,
   output rmc_pkg::status_type       status,
   input  wire logic signed [31:0]   sample_0,
   input  wire logic signed [31:0]   sample_1,
   input  wire logic signed [31:0]   sample_2,
   input  wire logic signed [31:0]   sample_3,
   output logic                      rsp_kind,
   output logic [1:0]                rsp_row,
   output logic [1:0]                rsp_col,
   output logic signed [63:0]        rsp_value,
   output logic                      rsp_last
);

   localparam logic [1:0] LastIdx = 2'(DIM - 1);
   localparam logic [63:0] PosMax = {1'b0, {63{1'b1}}};

   logic [rmc_pkg::CountW-1:0]  count_ff;
   logic signed [31:0]          mean_ff [rmc_pkg::StoreDim];
   logic signed [63:0]          cov_ff  [rmc_pkg::StoreDim * rmc_pkg::StoreDim];
   logic signed [32:0]          res_ff  [rmc_pkg::StoreDim];
   logic signed [32:0]          ra_ff;
   logic [63:0]                 p_ff, t1_ff, tm_ff, dm_ff;
   logic                        neg_ff;
   logic [1:0]                  a_ff, a_in, b_ff, b_in;
   logic [1:0]                  op_ff;

   logic signed [31:0]  samples [rmc_pkg::StoreDim];
   logic [3:0]          idx;
   logic [1:0]          rsel;
   logic signed [32:0]  rval;
   logic [32:0]         rval_neg, ra_neg;
   logic [31:0]         rval_mag, ra_mag;
   logic signed [63:0]  cov_cur;
   logic [63:0]         cov_mag;
   logic [63:0]         div_dividend, div_q;
   logic                div_done;
   logic signed [65:0]  dec_s, term_s, sum_s;
   logic signed [63:0]  sum_sat;
   logic signed [33:0]  mean_step, mean_sum;

   assign samples[0] = sample_0;
   assign samples[1] = sample_1;
   assign samples[2] = sample_2;
   assign samples[3] = sample_3;

   assign idx      = {a_ff, b_ff};
   assign rsel     = cmd.res_sel_b ? b_ff : a_ff;
   assign rval     = res_ff[rsel];
   assign rval_neg = 33'(-rval);
   assign rval_mag = rval[32] ? rval_neg[31:0] : rval[31:0];
   assign ra_neg   = 33'(-ra_ff);
   assign ra_mag   = ra_ff[32] ? ra_neg[31:0] : ra_ff[31:0];
   assign cov_cur  = cov_ff[idx];
   assign cov_mag  = cov_cur[63] ? 64'(-cov_cur) : 64'(cov_cur);

   always_comb begin
      unique case (cmd.div_op)
         rmc_pkg::DivProd: div_dividend = p_ff;
         rmc_pkg::DivTerm: div_dividend = t1_ff;
         rmc_pkg::DivCov:  div_dividend = cov_mag;
         rmc_pkg::DivMean: div_dividend = {32'd0, rval_mag};
         default:          div_dividend = p_ff;
      endcase
   end

   rmc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Decayed covariance plus the new term, exact, then clamped to 64 bits.
   always_comb begin
      dec_s  = cov_cur[63] ? -$signed({2'b00, dm_ff}) : $signed({2'b00, dm_ff});
      term_s = neg_ff ? -$signed({2'b00, tm_ff}) : $signed({2'b00, tm_ff});
      sum_s  = dec_s + term_s;
      if (sum_s > $signed({2'b00, PosMax})) begin
         sum_sat = $signed(PosMax);
      end else if (sum_s < -$signed({2'b00, PosMax}) - 66'sd1) begin
         sum_sat = $signed(~PosMax);
      end else begin
         sum_sat = sum_s[63:0];
      end
   end

   assign mean_step = rval[32] ? -$signed({1'b0, div_q[32:0]}) : $signed({1'b0, div_q[32:0]});
   assign mean_sum  = 34'(mean_ff[a_ff]) + mean_step;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      unique case (cmd.idx_op)
         rmc_pkg::IdxHold: ;
         rmc_pkg::IdxFirst: begin
            a_in = '0;
            b_in = '0;
         end
         rmc_pkg::IdxNext: begin
            if (b_ff == LastIdx) begin
               b_in = '0;
               a_in = a_ff + 2'd1;
            end else begin
               b_in = b_ff + 2'd1;
            end
         end
         rmc_pkg::IdxNextA: a_in = a_ff + 2'd1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff <= '0;
         for (int i = 0; i < rmc_pkg::StoreDim; i++) begin
            mean_ff[i] <= '0;
         end
         for (int i = 0; i < rmc_pkg::StoreDim * rmc_pkg::StoreDim; i++) begin
            cov_ff[i] <= '0;
         end
      end else begin
         if (cmd.load && count_ff != '1) begin
            count_ff <= count_ff + 32'd1;
         end
         if (div_done && op_ff == rmc_pkg::DivMean) begin
            mean_ff[a_ff] <= mean_sum[31:0];
         end
         if (cmd.cov_wr) begin
            cov_ff[idx] <= sum_sat;
         end
      end
      if (reset) begin
         a_ff <= '0;
         b_ff <= '0;
      end else begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
      if (cmd.load) begin
         for (int i = 0; i < rmc_pkg::StoreDim; i++) begin
            res_ff[i] <= 33'(samples[i]) - 33'(mean_ff[i]);
         end
      end
      if (cmd.lat_a) begin
         ra_ff <= rval;
      end
      if (cmd.lat_p) begin
         p_ff   <= ra_mag * rval_mag;
         neg_ff <= ra_ff[32] ^ rval[32];
      end
      if (cmd.div_start) begin
         op_ff <= cmd.div_op;
      end
      if (div_done) begin
         unique case (op_ff)
            rmc_pkg::DivProd: t1_ff <= div_q;
            rmc_pkg::DivTerm: tm_ff <= t1_ff - div_q;
            rmc_pkg::DivCov:  dm_ff <= cov_mag - div_q;
            rmc_pkg::DivMean: ;
            default: ;
         endcase
      end
   end

   assign status.div_done = div_done;
   assign status.a_last   = a_ff == LastIdx;
   assign status.b_last   = b_ff == LastIdx;

   assign rsp_kind  = cmd.emit_cov;
   assign rsp_row   = a_ff;
   assign rsp_col   = cmd.emit_cov ? b_ff : 2'd0;
   assign rsp_value = cmd.emit_cov ? cov_cur : 64'(mean_ff[a_ff]);
   assign rsp_last  = cmd.emit_cov && a_ff == LastIdx && b_ff == LastIdx;

endmodule

`default_nettype wire

>>> src/rmc_ctrl.sv
// Controller state machine: sequences the per-entry update, the mean update and emission.
// Depends on rmc_pkg.
`default_nettype none

module rmc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_cmd,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire rmc_pkg::status_type status,
   output rmc_pkg::cmd_type         cmd
);

   localparam logic [3:0] StIdle = 4'd0;
   localparam logic [3:0] StRa   = 4'd1;
   localparam logic [3:0] StMul  = 4'd2;
   localparam logic [3:0] StD1   = 4'd3;
   localparam logic [3:0] StW1   = 4'd4;
   localparam logic [3:0] StD2   = 4'd5;
   localparam logic [3:0] StW2   = 4'd6;
   localparam logic [3:0] StD3   = 4'd7;
   localparam logic [3:0] StW3   = 4'd8;
   localparam logic [3:0] StWr   = 4'd9;
   localparam logic [3:0] StMd   = 4'd10;
   localparam logic [3:0] StMw   = 4'd11;
   localparam logic [3:0] StEm   = 4'd12;
   localparam logic [3:0] StEc   = 4'd13;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         StIdle: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == rmc_pkg::CmdClear) begin
                  cmd.clear = 1'b1;
               end else begin
                  cmd.load   = 1'b1;
                  cmd.idx_op = rmc_pkg::IdxFirst;
                  state_in   = StRa;
               end
            end
         end
         StRa: begin
            cmd.lat_a = 1'b1;
            state_in  = StMul;
         end
         StMul: begin
            cmd.res_sel_b = 1'b1;
            cmd.lat_p     = 1'b1;
            state_in      = StD1;
         end
         StD1: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = rmc_pkg::DivProd;
            state_in      = StW1;
         end
         StW1: if (status.div_done) state_in = StD2;
         StD2: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = rmc_pkg::DivTerm;
            state_in      = StW2;
         end
         StW2: if (status.div_done) state_in = StD3;
         StD3: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = rmc_pkg::DivCov;
            state_in      = StW3;
         end
         StW3: if (status.div_done) state_in = StWr;
         StWr: begin
            cmd.cov_wr = 1'b1;
            if (status.a_last && status.b_last) begin
               cmd.idx_op = rmc_pkg::IdxFirst;
               state_in   = StMd;
            end else begin
               cmd.idx_op = rmc_pkg::IdxNext;
               state_in   = StRa;
            end
         end
         StMd: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = rmc_pkg::DivMean;
            state_in      = StMw;
         end
         StMw: begin
            cmd.div_op = rmc_pkg::DivMean;
            if (status.div_done) begin
               if (status.a_last) begin
                  cmd.idx_op = rmc_pkg::IdxFirst;
                  state_in   = StEm;
               end else begin
                  cmd.idx_op = rmc_pkg::IdxNextA;
                  state_in   = StMd;
               end
            end
         end
         StEm: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.a_last) begin
                  cmd.idx_op = rmc_pkg::IdxFirst;
                  state_in   = StEc;
               end else begin
                  cmd.idx_op = rmc_pkg::IdxNextA;
               end
            end
         end
         StEc: begin
            rsp_valid    = 1'b1;
            cmd.emit_cov = 1'b1;
            if (rsp_ready) begin
               if (status.a_last && status.b_last) begin
                  state_in = StIdle;
               end else begin
                  cmd.idx_op = rmc_pkg::IdxNext;
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> src/running_mean_covariance_unit.sv
// Top level of the running mean and covariance unit (Welford update).
// Depends on rmc_pkg, rmc_if, rmc_ctrl and rmc_datapath.
//
// Usage: req_port carries one word per command. cmd = add takes the first DIM
// elements of the sample vector (signed Q15.16), bumps the sample count (which
// holds at its maximum), and updates the covariance (Q31.32, saturating) and the
// mean. cmd = clear zeroes the count, the mean and the covariance and produces
// no response.
// After an add, rsp_port delivers DIM mean words, then DIM*DIM covariance words
// in row-major order, with last set on the final covariance word.
// An add needs, for each covariance entry, three 64-bit by 32-bit divisions by the
// count and for each mean element one, all on a single bit-serial divider that
// resolves one quotient bit per cycle, followed by the response words.
// The block works on one word at a time; req_port.ready is high only while idle.
// When the receiver stalls, the current response word and the sequence hold
// until it is taken. Reset (synchronous, active high) clears the statistics and
// returns the controller to idle.
`default_nettype none

module running_mean_covariance_unit #(
   parameter int DIM = rmc_pkg::DimDefault
) (
   input wire logic clock,
   input wire logic reset,
   rmc_req_if.sink   req_port,
   rmc_rsp_if.source rsp_port
);

   rmc_pkg::cmd_type    cmd;
   rmc_pkg::status_type status;

   rmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_cmd   (req_port.cmd),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rmc_datapath #(.DIM(DIM)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .sample_0  (req_port.sample_0),
      .sample_1  (req_port.sample_1),
      .sample_2  (req_port.sample_2),
      .sample_3  (req_port.sample_3),
      .rsp_kind  (rsp_port.kind),
      .rsp_row   (rsp_port.row_index),
      .rsp_col   (rsp_port.col_index),
      .rsp_value (rsp_port.value),
      .rsp_last  (rsp_port.last)
   );

endmodule

`default_nettype wire

>>> src/rmc_checker.sv
// Port-level checks for the running mean and covariance unit, bound to the top level.
// Depends on rmc_pkg and rmc_if.
`default_nettype none

module rmc_checker (
   input wire logic  clock,
   input wire logic  reset,
   rmc_req_if.sink   req_port,
   rmc_rsp_if.source rsp_port
);

   // A stalled response word keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && !rsp_port.ready |=> rsp_port.valid && $stable(rsp_port.value))
      else $error("response word changed while stalled");

   // The block never takes a new word while it is still sending results.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_port.ready && rsp_port.valid))
      else $error("request accepted during response");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_port.valid)
      else $error("response valid after reset");

   a_clear_silent: assert property (@(posedge clock) disable iff (reset)
      req_port.valid && req_port.ready && req_port.cmd == rmc_pkg::CmdClear
      |=> !rsp_port.valid)
      else $error("clear produced a response");

   a_last_is_cov: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.last |-> rsp_port.kind)
      else $error("last flag on a mean word");

endmodule

bind running_mean_covariance_unit rmc_checker u_rmc_checker (
   .clock    (clock),
   .reset    (reset),
   .req_port (req_port),
   .rsp_port (rsp_port)
);

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for running_mean_covariance_unit: directed and random
// sample words checked word by word against a local Welford predictor.
// Depends on rmc_pkg, rmc_if and the running_mean_covariance_unit RTL.
`default_nettype none

module tb_top;

   // The limit covers all items with stalls.
   localparam longint CycleLimit = 20_000_000;
   localparam int NumRandom = 310;

   typedef struct {
      logic               kind;
      logic [1:0]         row_index;
      logic [1:0]         col_index;
      logic signed [63:0] value;
      logic               last;
   } entry_type;

   logic clock;
   logic reset;

   rmc_req_if req_bus ();
   rmc_rsp_if rsp_bus ();

   running_mean_covariance_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_port(req_bus),
      .rsp_port(rsp_bus)
   );

   // Predictor state, a copy of what the block should hold.
   logic [31:0]        stat_count;
   logic signed [31:0] stat_mean [rmc_pkg::StoreDim];
   logic signed [63:0] stat_cov  [rmc_pkg::StoreDim*rmc_pkg::StoreDim];

   entry_type pending_entries[$];
   int  error_count;
   int  adds_sent;
   int  clears_sent;
   int  words_checked;
   bit  steady_phase;
   longint cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Magnitude of a signed 64-bit value; the minimum maps to 2^63, which fits.
   function automatic logic [63:0] magnitude(input logic signed [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   // Exact sum of two sign-magnitude values, clamped to the signed 64-bit range.
   function automatic logic signed [63:0] clamp_sum(input logic an, input logic [63:0] am,
                                                    input logic bn, input logic [63:0] bm);
      logic        rn;
      logic [64:0] rm;
      if (an == bn) begin
         rn = an;
         rm = {1'b0, am} + {1'b0, bm};
      end else if (am >= bm) begin
         rn = an;
         rm = {1'b0, am - bm};
      end else begin
         rn = bn;
         rm = {1'b0, bm - am};
      end
      if (rn) begin
         if (rm >= 65'h0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
         return -$signed(rm[63:0]);
      end
      if (rm >= 65'h0_8000_0000_0000_0000) return 64'sh7FFF_FFFF_FFFF_FFFF;
      return $signed(rm[63:0]);
   endfunction

   function automatic void clear_stats();
      stat_count = '0;
      for (int i = 0; i < rmc_pkg::StoreDim; i++) stat_mean[i] = '0;
      for (int i = 0; i < rmc_pkg::StoreDim*rmc_pkg::StoreDim; i++) stat_cov[i] = '0;
   endfunction

   // Applies one accepted word to the predictor and queues the expected words.
   function automatic void apply_word(input logic cmd,
                                      input logic signed [31:0] s [rmc_pkg::StoreDim]);
      longint    resid [rmc_pkg::StoreDim];
      logic [63:0] n, pa, pb, p, t1, tm, cm, dm;
      entry_type e;
      if (cmd == rmc_pkg::CmdClear) begin
         clear_stats();
         return;
      end
      if (stat_count != 32'hFFFF_FFFF) stat_count = stat_count + 1;
      n = {32'd0, stat_count};
      for (int a = 0; a < rmc_pkg::DimDefault; a++)
         resid[a] = longint'(s[a]) - longint'(stat_mean[a]);
      for (int a = 0; a < rmc_pkg::DimDefault; a++) begin
         for (int b = 0; b < rmc_pkg::DimDefault; b++) begin
            cm = magnitude(stat_cov[a*rmc_pkg::StoreDim+b]);
            pa = magnitude(resid[a]);
            pb = magnitude(resid[b]);
            p  = pa * pb;
            t1 = p / n;
            tm = t1 - t1 / n;
            dm = cm - cm / n;
            stat_cov[a*rmc_pkg::StoreDim+b] = clamp_sum(stat_cov[a*rmc_pkg::StoreDim+b][63],
                                                        dm, resid[a][63] ^ resid[b][63], tm);
         end
      end
      // Signed division truncates toward zero, as the block's mean step does.
      for (int a = 0; a < rmc_pkg::DimDefault; a++)
         stat_mean[a] = 32'(longint'(stat_mean[a]) + resid[a] / longint'(n));
      for (int a = 0; a < rmc_pkg::DimDefault; a++) begin
         e.kind = 1'b0; e.row_index = 2'(a); e.col_index = 2'd0;
         e.value = 64'(stat_mean[a]); e.last = 1'b0;
         pending_entries.push_back(e);
      end
      for (int a = 0; a < rmc_pkg::DimDefault; a++) begin
         for (int b = 0; b < rmc_pkg::DimDefault; b++) begin
            e.kind = 1'b1; e.row_index = 2'(a); e.col_index = 2'(b);
            e.value = stat_cov[a*rmc_pkg::StoreDim+b];
            e.last = (a == rmc_pkg::DimDefault-1) && (b == rmc_pkg::DimDefault-1);
            pending_entries.push_back(e);
         end
      end
   endfunction

   function automatic int idle_gap();
      if (steady_phase) return 0;
      return ($urandom_range(0, 99) < 24) ? $urandom_range(1, 4) : 0;
   endfunction

   // Sends one word and waits for the handshake. Valid stays high between
   // back-to-back words so it is never lowered and raised in one step.
   task automatic send_word(input logic cmd, input logic signed [31:0] s0,
                            input logic signed [31:0] s1, input logic signed [31:0] s2,
                            input logic signed [31:0] s3);
      int gap;
      logic signed [31:0] s [rmc_pkg::StoreDim];
      gap = idle_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.cmd      <= cmd;
      req_bus.sample_0 <= s0;
      req_bus.sample_1 <= s1;
      req_bus.sample_2 <= s2;
      req_bus.sample_3 <= s3;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      s[0] = s0; s[1] = s1; s[2] = s2; s[3] = s3;
      apply_word(cmd, s);
      if (cmd == rmc_pkg::CmdClear) clears_sent++;
      else adds_sent++;
   endtask

   task automatic send_add(input logic signed [31:0] s0, input logic signed [31:0] s1,
                           input logic signed [31:0] s2, input logic signed [31:0] s3);
      send_word(rmc_pkg::CmdAdd, s0, s1, s2, s3);
   endtask

   task automatic send_clear();
      send_word(rmc_pkg::CmdClear, $urandom, $urandom, $urandom, $urandom);
   endtask

   // Random element: half full-range, some small values near zero, some extremes.
   function automatic logic signed [31:0] pick_element();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) return $urandom;
      if (sel < 8) return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      if (sel == 8) return 32'sh7FFF_FFFF;
      return 32'sh8000_0000;
   endfunction

   // Extremes of the fields, the first sample after reset, and a clear
   // that also carries extreme sample bits which must be ignored.
   task automatic test_extremes();
      send_add('0, '0, '0, '0);
      send_add(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_add(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_add(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_add(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_add(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_0001, -32'sh0000_0001);
      send_word(rmc_pkg::CmdClear, 32'sh7FFF_FFFF, 32'sh8000_0000, -1, 32'sh5555_5555);
   endtask

   // Two clears in a row between runs of samples, with the first sample right after them.
   task automatic test_clear_restart();
      send_add(32'sh1234_5678, -32'sh0ABC_DEF0, 32'sh0000_8000, 32'sh7FFF_0000);
      send_add(-32'sh1234_5678, 32'sh0ABC_DEF0, -32'sh0000_8000, 32'sh8000_FFFF);
      send_clear();
      send_clear();
      send_add(32'sh2AAA_AAAA, 32'sh5555_5555, -32'sh2AAA_AAAA, -1);
      send_add(32'sh2AAA_AAAA, 32'sh5555_5555, -32'sh2AAA_AAAA, -1);
      send_add(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1);
      send_add(-1, -1, -1, -1);
      send_clear();
   endtask

   // Mostly well-formed runs of samples with random content, broken by clears.
   task automatic test_random();
      for (int i = 0; i < NumRandom; i++) begin
         steady_phase = (i >= 120) && (i < 170);
         if ($urandom_range(0, 99) < 6) send_clear();
         else send_add(pick_element(), pick_element(), pick_element(), pick_element());
      end
      steady_phase = 1'b0;
   endtask

   // The receiver stalls at random, except during the steady stretch.
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else if (steady_phase) rsp_bus.ready <= 1'b1;
      else rsp_bus.ready <= ($urandom_range(0, 99) >= 24);
   end

   // Response checker: each accepted word against the oldest expectation.
   always @(posedge clock) begin
      entry_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         words_checked++;
         if (pending_entries.size() == 0) begin
            $display("%0t: unexpected word kind=%0d row=%0d col=%0d value=%0d last=%0d",
                     $time, rsp_bus.kind, rsp_bus.row_index, rsp_bus.col_index,
                     rsp_bus.value, rsp_bus.last);
            error_count++;
         end else begin
            e = pending_entries.pop_front();
            if (rsp_bus.kind !== e.kind) begin
               $display("%0t: kind expected %0d actual %0d", $time, e.kind, rsp_bus.kind);
               error_count++;
            end
            if (rsp_bus.row_index !== e.row_index) begin
               $display("%0t: row_index expected %0d actual %0d",
                        $time, e.row_index, rsp_bus.row_index);
               error_count++;
            end
            if (rsp_bus.col_index !== e.col_index) begin
               $display("%0t: col_index expected %0d actual %0d",
                        $time, e.col_index, rsp_bus.col_index);
               error_count++;
            end
            if (rsp_bus.value !== e.value) begin
               $display("%0t: value [%0d][%0d] expected %0d actual %0d",
                        $time, e.row_index, e.col_index, e.value, rsp_bus.value);
               error_count++;
            end
            if (rsp_bus.last !== e.last) begin
               $display("%0t: last expected %0d actual %0d", $time, e.last, rsp_bus.last);
               error_count++;
            end
         end
      end
   end

   // Watchdog: a hung block ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout with %0d words outstanding", $time, pending_entries.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      error_count   = 0;
      adds_sent     = 0;
      clears_sent   = 0;
      words_checked = 0;
      steady_phase  = 1'b0;
      clear_stats();
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.cmd      <= rmc_pkg::CmdAdd;
      req_bus.sample_0 <= '0;
      req_bus.sample_1 <= '0;
      req_bus.sample_2 <= '0;
      req_bus.sample_3 <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_clear_restart();
      test_random();
      req_bus.valid <= 1'b0;

      while (pending_entries.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Sent %0d sample words and %0d clears; checked %0d response words.",
               adds_sent, clears_sent, words_checked);
      $display("Covered field extremes, clears between runs and random stalls on both sides.");
      if (error_count == 0 && pending_entries.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
